/* rtl/sisi_pkg.sv */
package sisi_pkg;

   localparam int TABLE_DEPTH_DEF = 32;

   localparam int KEY_W  = 31;
   localparam int SLOT_W = 5;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_PRESENT  = 2'd1,
      ST_FULL     = 2'd2,
      ST_LOADED   = 2'd3
   } status_type;

   typedef enum logic {
      FN_LOAD   = 1'b0,
      FN_SEARCH = 1'b1
   } func_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] slot;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } table_ctl_type;

endpackage

/* rtl/sisi_table.sv */
module sisi_table #(
   parameter int TABLE_DEPTH = sisi_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  sisi_pkg::table_ctl_type        ctl,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  sisi_pkg::entry_type            wr_data,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output sisi_pkg::entry_type            rd_data
);

   sisi_pkg::entry_type mem [TABLE_DEPTH];
   sisi_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sisi_ctrl.sv */
module sisi_ctrl #(
   parameter int TABLE_DEPTH = sisi_pkg::TABLE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_func,
   input  logic [sisi_pkg::KEY_W-1:0]       req_key,
   input  logic [sisi_pkg::SLOT_W-1:0]      req_slot,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [sisi_pkg::SLOT_W-1:0]      rsp_slot_out,
   output sisi_pkg::table_ctl_type          tbl_ctl,
   output logic [$clog2(TABLE_DEPTH)-1:0]   tbl_wr_addr,
   output sisi_pkg::entry_type              tbl_wr_data,
   output logic [$clog2(TABLE_DEPTH)-1:0]   tbl_rd_addr,
   input  sisi_pkg::entry_type              tbl_rd_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SRCH  = 5'b00010,
      S_CMP   = 5'b00100,
      S_SHIFT = 5'b01000,
      S_PLACE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;          // exclusive upper bound
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] pos_ff, pos_in;        // free position during the shift
   logic [sisi_pkg::KEY_W-1:0] key_ff, key_in;
   logic rsp_valid_ff, rsp_valid_in;
   sisi_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [sisi_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic [CW-1:0] mid_calc;
   logic [CW-1:0] pos_dec;
   logic full;
   sisi_pkg::entry_type new_entry;

   assign full      = (count_ff == DEPTH_C);
   assign mid_calc  = lo_ff + ((hi_ff - lo_ff - CW'(1)) >> 1);
   assign pos_dec   = pos_ff - CW'(1);
   assign new_entry = '{key: key_ff, slot: sisi_pkg::SLOT_W'(count_ff)};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      tbl_ctl       = '{rd_en: 1'b0, wr_en: 1'b0};
      tbl_wr_addr   = pos_ff[AW-1:0];
      tbl_wr_data   = new_entry;
      tbl_rd_addr   = mid_calc[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in = req_key;
               if (req_func == sisi_pkg::FN_LOAD) begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     rsp_status_in = sisi_pkg::ST_FULL;
                     rsp_slot_in   = '0;
                  end else begin
                     tbl_ctl.wr_en = 1'b1;
                     tbl_wr_addr   = count_ff[AW-1:0];
                     tbl_wr_data   = '{key: req_key, slot: req_slot};
                     count_in      = count_ff + CW'(1);
                     rsp_status_in = sisi_pkg::ST_LOADED;
                     rsp_slot_in   = req_slot;
                  end
               end else begin
                  lo_in    = '0;
                  hi_in    = count_ff;
                  state_in = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               tbl_ctl.rd_en = 1'b1;
               mid_in        = mid_calc;
               state_in      = S_CMP;
            end else if (full) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sisi_pkg::ST_FULL;
               rsp_slot_in   = '0;
               state_in      = S_IDLE;
            end else if (count_ff == '0) begin
               pos_in   = '0;
               state_in = S_PLACE;
            end else begin
               // Start moving entries up from the top of the table.
               tbl_ctl.rd_en = 1'b1;
               tbl_rd_addr   = AW'(count_ff - CW'(1));
               pos_in        = count_ff;
               state_in      = S_SHIFT;
            end
         end
         S_CMP: begin
            if (tbl_rd_data.key == key_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sisi_pkg::ST_PRESENT;
               rsp_slot_in   = tbl_rd_data.slot;
               state_in      = S_IDLE;
            end else begin
               if (key_ff > tbl_rd_data.key) begin
                  lo_in = mid_ff + CW'(1);
               end else begin
                  hi_in = mid_ff;
               end
               state_in = S_SRCH;
            end
         end
         S_SHIFT: begin
            tbl_ctl.wr_en = 1'b1;
            if (tbl_rd_data.key > key_ff) begin
               // Move the entry up and fetch the next lower one in the same cycle.
               tbl_wr_data = tbl_rd_data;
               pos_in      = pos_dec;
               if (pos_dec == '0) begin
                  state_in = S_PLACE;
               end else begin
                  tbl_ctl.rd_en = 1'b1;
                  tbl_rd_addr   = AW'(pos_dec - CW'(1));
               end
            end else begin
               count_in      = count_ff + CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = sisi_pkg::ST_INSERTED;
               rsp_slot_in   = new_entry.slot;
               state_in      = S_IDLE;
            end
         end
         S_PLACE: begin
            tbl_ctl.wr_en = 1'b1;
            count_in      = count_ff + CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = sisi_pkg::ST_INSERTED;
            rsp_slot_in   = new_entry.slot;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count exceeds table depth");

   a_rsp_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result strobe while a transaction is still in progress");

   a_start_progress : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid_ff))
      else $error("accepted transaction neither started nor completed");

   a_shift_pos : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT || state_ff == S_PLACE) |-> (pos_ff <= count_ff && !full))
      else $error("shift position outside the valid entries");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + CW'(1) && rsp_valid_ff))
      else $error("entry count changed without a completed insert or load");

endmodule

/* rtl/sorted_index_search_insert.sv */
// Sorted index table of (key, slot) pairs held in one single-port-read,
// single-port-write synchronous memory. Pulse start while busy is low to
// issue a transaction; exactly one result appears later on rsp_* for one
// cycle with rsp_valid high, and it must be captured then, since the block
// has no way to hold it. A load returns its result in the cycle after it is
// accepted. A search makes at most ceil(log2(n+1)) binary-search probes for
// n stored entries; each probe reads one entry (S_SRCH) and compares it
// (S_CMP), and a miss on a full table returns ST_FULL. An insert after a
// miss moves one entry up per cycle and then writes the new key in a write
// of its own. A new transaction can be accepted at the edge that ends the
// result cycle. This timing follows from the registered read of the table
// memory and its single read port. The table needs no clearing after
// reset: only entries below the entry count are read.
module sorted_index_search_insert #(
   parameter int TABLE_DEPTH = sisi_pkg::TABLE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_func,
   input  logic [sisi_pkg::KEY_W-1:0]  req_key,
   input  logic [sisi_pkg::SLOT_W-1:0] req_slot,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [sisi_pkg::SLOT_W-1:0] rsp_slot_out
);

   localparam int AW = $clog2(TABLE_DEPTH);

   sisi_pkg::table_ctl_type tbl_ctl;
   logic [AW-1:0]           tbl_wr_addr;
   logic [AW-1:0]           tbl_rd_addr;
   sisi_pkg::entry_type     tbl_wr_data;
   sisi_pkg::entry_type     tbl_rd_data;

   sisi_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_key      (req_key),
      .req_slot     (req_slot),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_slot_out (rsp_slot_out),
      .tbl_ctl      (tbl_ctl),
      .tbl_wr_addr  (tbl_wr_addr),
      .tbl_wr_data  (tbl_wr_data),
      .tbl_rd_addr  (tbl_rd_addr),
      .tbl_rd_data  (tbl_rd_data)
   );

   sisi_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

endmodule

/* verif/sorted_index_search_insert_tb.sv */
`timescale 1ns / 1ps

module sorted_index_search_insert_tb;

   localparam int DEPTH = sisi_pkg::TABLE_DEPTH_DEF;
   localparam int IW = $clog2(DEPTH);
   localparam int KEY_W = sisi_pkg::KEY_W;
   localparam int SLOT_W = sisi_pkg::SLOT_W;
   localparam int DRAIN_LIMIT = 2000;
   localparam int TAIL_CYCLES = 60;

   typedef struct {
      sisi_pkg::status_type status;
      bit [SLOT_W-1:0]      slot;
   } index_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_func;
   logic [KEY_W-1:0]  req_key;
   logic [SLOT_W-1:0] req_slot;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [SLOT_W-1:0] rsp_slot_out;

   // Mirror of the index table, updated when a transaction is accepted.
   bit [KEY_W-1:0]  key_tbl [DEPTH];
   bit [SLOT_W-1:0] slot_tbl [DEPTH];
   int              entry_count;

   index_result_type pending_results [$];
   int               sender_idle_pct;
   int               error_count;
   int               sent_count;
   int               checked_count;
   int               status_count [4];

   sorted_index_search_insert #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_key      (req_key),
      .req_slot     (req_slot),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_slot_out (rsp_slot_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic index_result_type apply_index_op(sisi_pkg::func_type fn,
                                                       bit [KEY_W-1:0] key,
                                                       bit [SLOT_W-1:0] slot);
      index_result_type res;
      int               lo;
      int               hi;
      int               mid;
      int               pos;
      bit               hit;
      res.slot = '0;
      if (fn == sisi_pkg::FN_LOAD) begin
         if (entry_count >= DEPTH) begin
            res.status = sisi_pkg::ST_FULL;
         end else begin
            key_tbl[IW'(entry_count)] = key;
            slot_tbl[IW'(entry_count)] = slot;
            entry_count++;
            res.status = sisi_pkg::ST_LOADED;
            res.slot = slot;
         end
      end else begin
         lo = 0;
         hi = entry_count - 1;
         hit = 1'b0;
         while (!hit && lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_tbl[IW'(mid)] == key) begin
               hit = 1'b1;
               res.slot = slot_tbl[IW'(mid)];
            end else if (key > key_tbl[IW'(mid)]) begin
               lo = mid + 1;
            end else begin
               hi = mid - 1;
            end
         end
         if (hit) begin
            res.status = sisi_pkg::ST_PRESENT;
         end else if (entry_count >= DEPTH) begin
            res.status = sisi_pkg::ST_FULL;
         end else begin
            // Larger keys move up one place; the new key lands in the gap.
            pos = entry_count;
            while (pos > 0 && key_tbl[IW'(pos-1)] > key) begin
               key_tbl[IW'(pos)] = key_tbl[IW'(pos-1)];
               slot_tbl[IW'(pos)] = slot_tbl[IW'(pos-1)];
               pos--;
            end
            res.slot = entry_count[SLOT_W-1:0];
            key_tbl[IW'(pos)] = key;
            slot_tbl[IW'(pos)] = res.slot;
            entry_count++;
            res.status = sisi_pkg::ST_INSERTED;
         end
      end
      return res;
   endfunction

   task automatic note_error(string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("[%0t] ERROR: %s", $realtime, msg);
      end
   endtask

   // Leaves start high after acceptance; the next call either keeps it high
   // with new fields or lowers it for an idle gap.
   task automatic send_op(sisi_pkg::func_type fn, bit [KEY_W-1:0] key,
                          bit [SLOT_W-1:0] slot);
      while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         req_func <= 1'($urandom);
         req_key <= KEY_W'($urandom);
         req_slot <= SLOT_W'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= fn;
      req_key <= key;
      req_slot <= slot;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_index_op(fn, key, slot));
      sent_count++;
   endtask

   function automatic bit [KEY_W-1:0] stored_key();
      if (entry_count == 0) begin
         return KEY_W'($urandom);
      end
      return key_tbl[IW'($urandom_range(0, entry_count - 1))];
   endfunction

   always @(posedge clock) begin
      index_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            note_error($sformatf("unexpected result status=%0d slot=%0d",
                                 rsp_status, rsp_slot_out));
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            status_count[want.status]++;
            if (rsp_status !== want.status || rsp_slot_out !== want.slot) begin
               note_error($sformatf(
                  "result %0d: expected status=%s slot=%0d, got status=%0d slot=%0d",
                  checked_count, want.status.name(), want.slot,
                  rsp_status, rsp_slot_out));
            end
         end
      end
   end

   task automatic test_directed();
      sender_idle_pct = 0;
      send_op(sisi_pkg::FN_SEARCH, 31'h2AAA_AAAA, 5'd7);   // miss on an empty table
      send_op(sisi_pkg::FN_LOAD, 31'd1, 5'd31);            // load below an existing key
      send_op(sisi_pkg::FN_LOAD, 31'h7FFF_FFFF, 5'd0);
      send_op(sisi_pkg::FN_LOAD, 31'h5555_5555, 5'd21);    // out of order
      send_op(sisi_pkg::FN_SEARCH, 31'd1, 5'd0);
      send_op(sisi_pkg::FN_SEARCH, 31'h7FFF_FFFF, 5'd31);
      send_op(sisi_pkg::FN_SEARCH, 31'h5555_5555, 5'd3);
      send_op(sisi_pkg::FN_SEARCH, 31'h2AAA_AAAA, 5'd12);
      send_op(sisi_pkg::FN_SEARCH, 31'd0, 5'd31);          // key zero goes in at the bottom
      send_op(sisi_pkg::FN_SEARCH, 31'd0, 5'd0);
      send_op(sisi_pkg::FN_SEARCH, 31'h4000_0000, 5'd9);
      send_op(sisi_pkg::FN_SEARCH, 31'd2, 5'd16);
      send_op(sisi_pkg::FN_LOAD, 31'd0, 5'd10);            // duplicate key appended at the top
      send_op(sisi_pkg::FN_SEARCH, 31'd0, 5'd1);
      send_op(sisi_pkg::FN_SEARCH, 31'h7FFF_FFFE, 5'd30);
   endtask

   // Mostly hits on stored keys, so that the table fills slowly across phases.
   task automatic test_random(int idle_pct, int n_items);
      int              pick;
      bit [KEY_W-1:0]  key;
      sender_idle_pct = idle_pct;
      repeat (n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 1) begin
            send_op(sisi_pkg::FN_LOAD, KEY_W'($urandom), SLOT_W'($urandom));
         end else if (pick < 2) begin
            send_op(sisi_pkg::FN_SEARCH, KEY_W'($urandom), SLOT_W'($urandom));
         end else if (pick < 4) begin
            key = stored_key();
            key = $urandom_range(0, 1) ? key + KEY_W'(1) : key - KEY_W'(1);
            send_op(sisi_pkg::FN_SEARCH, key, SLOT_W'($urandom));
         end else begin
            send_op(sisi_pkg::FN_SEARCH, stored_key(), SLOT_W'($urandom));
         end
      end
   endtask

   task automatic test_full_table();
      sender_idle_pct = 25;
      while (entry_count < DEPTH) begin
         send_op(sisi_pkg::FN_SEARCH, KEY_W'($urandom), SLOT_W'($urandom));
      end
      send_op(sisi_pkg::FN_LOAD, 31'h1234_5678, 5'd31);
      send_op(sisi_pkg::FN_SEARCH, key_tbl[0], 5'd0);
      send_op(sisi_pkg::FN_SEARCH, key_tbl[DEPTH-1], 5'd0);
      repeat (20) begin
         if ($urandom_range(0, 1)) begin
            send_op(sisi_pkg::FN_SEARCH, stored_key(), SLOT_W'($urandom));
         end else begin
            send_op(sisi_pkg::func_type'($urandom_range(0, 1)), KEY_W'($urandom),
                    SLOT_W'($urandom));
         end
      end
   endtask

   initial begin
      int wait_cycles;
      reset <= 1'b1;
      start <= 1'b0;
      req_func <= 1'b0;
      req_key <= '0;
      req_slot <= '0;
      entry_count = 0;
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      sender_idle_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(0, 370);
      test_random(67, 370);
      test_random(25, 370);
      test_full_table();
      start <= 1'b0;

      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         note_error($sformatf("%0d results never arrived", pending_results.size()));
      end

      $display("Sent %0d transactions, checked %0d results (%0d inserted, %0d found,",
               sent_count, checked_count, status_count[sisi_pkg::ST_INSERTED],
               status_count[sisi_pkg::ST_PRESENT]);
      $display("%0d loaded, %0d refused on a full table), %0d errors.",
               status_count[sisi_pkg::ST_LOADED], status_count[sisi_pkg::ST_FULL],
               error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout: the block stopped accepting transactions or returning results.");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
